// ===== rtl/srtc_pkg.sv =====
`default_nettype none

package srtc_pkg;

   // Default sizes of the range sample and of the beam angle.
   localparam int RANGE_BITS_DEFAULT = 16;
   localparam int ANGLE_BITS_DEFAULT = 16;

   // Rotation arithmetic: Q2.30 coordinates with headroom, residual angle in 1/2^32 turn.
   localparam int CORDIC_ITERS = 28;
   localparam int UNIT_SHIFT   = 30;
   localparam int X_W          = 34;
   localparam int Z_W          = 32;
   localparam int MAG_W        = 32;
   localparam logic signed [X_W-1:0] CORDIC_START = X_W'(652032874);

   // Arctangent of 2^-i in 1/2^32 turn.
   localparam logic [31:0] ATAN_TURN [CORDIC_ITERS] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
      32'd81, 32'd41, 32'd20, 32'd10, 32'd5
   };

   // Configuration port.
   localparam int CSR_INDEX_BITS = 8;
   localparam int CSR_DATA_BITS  = 16;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RANGE_LOW   = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RANGE_HIGH  = 8'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_ANGLE = 8'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ANGLE_STEP  = 8'd3;

   localparam logic [CSR_DATA_BITS-1:0] RANGE_LOW_RESET   = 16'd0;
   localparam logic [CSR_DATA_BITS-1:0] RANGE_HIGH_RESET  = 16'd65535;
   localparam logic [CSR_DATA_BITS-1:0] START_ANGLE_RESET = 16'h8000;
   localparam logic [CSR_DATA_BITS-1:0] ANGLE_STEP_RESET  = 16'd182;

   // Quadrant of the beam angle, from its top two bits.
   typedef enum logic [1:0] {
      QUAD_FIRST,
      QUAD_SECOND,
      QUAD_THIRD,
      QUAD_FOURTH
   } quadrant_type;

   // Vector handed from cell to cell.
   typedef struct packed {
      logic signed [X_W-1:0] x;
      logic signed [X_W-1:0] y;
      logic signed [Z_W-1:0] z;
   } cordic_vec_type;

endpackage

`default_nettype wire

// ===== rtl/srtc_req_if.sv =====
`default_nettype none

interface srtc_req_if #(
   parameter int RANGE_BITS = srtc_pkg::RANGE_BITS_DEFAULT
);
   logic                  valid;
   logic                  ready;
   logic [RANGE_BITS-1:0] range_mm;
   logic                  scan_end;

   modport source (output valid, output range_mm, output scan_end, input ready);
   modport sink   (input valid, input range_mm, input scan_end, output ready);
endinterface

`default_nettype wire

// ===== rtl/srtc_rsp_if.sv =====
`default_nettype none

interface srtc_rsp_if #(
   parameter int RANGE_BITS = srtc_pkg::RANGE_BITS_DEFAULT
);
   logic                       valid;
   logic                       ready;
   logic signed [RANGE_BITS:0] point_x;
   logic signed [RANGE_BITS:0] point_y;
   logic                       point_kept;
   logic                       last_of_scan;

   modport source (output valid, output point_x, output point_y, output point_kept,
                   output last_of_scan, input ready);
   modport sink   (input valid, input point_x, input point_y, input point_kept,
                   input last_of_scan, output ready);
endinterface

`default_nettype wire

// ===== rtl/srtc_csr_if.sv =====
`default_nettype none

interface srtc_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [srtc_pkg::CSR_INDEX_BITS-1:0] index;
   logic [srtc_pkg::CSR_DATA_BITS-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/srtc_front.sv =====
`default_nettype none

module srtc_front #(
   parameter int RANGE_BITS = srtc_pkg::RANGE_BITS_DEFAULT,
   parameter int ANGLE_BITS = srtc_pkg::ANGLE_BITS_DEFAULT,
   parameter int SIDE_W     = RANGE_BITS + 4
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   srtc_csr_if.sink                      csr,
   srtc_req_if.sink                      req,
   output logic                          out_valid,
   input  wire logic                     out_ready,
   output srtc_pkg::cordic_vec_type      out_vec,
   output logic [SIDE_W-1:0]             out_side
);

   localparam int CMP_W = (RANGE_BITS > 16) ? RANGE_BITS : 16;

   logic [15:0] range_low_ff, range_high_ff, start_angle_ff, angle_step_ff;

   logic [ANGLE_BITS-1:0] beam_angle_ff, beam_angle_in;
   logic                  pending_ff;

   logic                  valid_ff;
   logic [ANGLE_BITS-1:0] angle_ff, angle_in;
   logic [RANGE_BITS-1:0] range_ff;
   logic                  kept_ff, kept_in;
   logic                  last_ff;

   logic                  accept;
   logic signed [31:0]    start_ext;
   logic [CMP_W-1:0]      r_cmp;

   // Configuration writes are always taken.
   assign csr.ready = 1'b1;

   // The stage register is free when empty or when its contents move on.
   assign req.ready = !valid_ff || out_ready;
   assign accept    = req.valid && req.ready;

   // Beam angle: start angle on the first beam of a scan, else the running angle.
   always_comb begin
      start_ext     = 32'(signed'(start_angle_ff));
      angle_in      = pending_ff ? start_ext[ANGLE_BITS-1:0] : beam_angle_ff;
      beam_angle_in = angle_in + ANGLE_BITS'(angle_step_ff);
   end

   // Range gate, both limits exclusive.
   always_comb begin
      r_cmp   = CMP_W'(req.range_mm);
      kept_in = (CMP_W'(range_low_ff) < r_cmp) && (r_cmp < CMP_W'(range_high_ff));
   end

   // Configuration registers, angle tracker and stage valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         range_low_ff   <= srtc_pkg::RANGE_LOW_RESET;
         range_high_ff  <= srtc_pkg::RANGE_HIGH_RESET;
         start_angle_ff <= srtc_pkg::START_ANGLE_RESET;
         angle_step_ff  <= srtc_pkg::ANGLE_STEP_RESET;
         beam_angle_ff  <= '0;
         pending_ff     <= 1'b1;
         valid_ff       <= 1'b0;
      end else begin
         if (csr.valid) begin
            unique case (csr.index)
               srtc_pkg::CSR_RANGE_LOW:   range_low_ff   <= csr.data;
               srtc_pkg::CSR_RANGE_HIGH:  range_high_ff  <= csr.data;
               srtc_pkg::CSR_START_ANGLE: start_angle_ff <= csr.data;
               srtc_pkg::CSR_ANGLE_STEP:  angle_step_ff  <= csr.data;
               default: ;
            endcase
         end
         if (accept) begin
            beam_angle_ff <= beam_angle_in;
            pending_ff    <= req.scan_end;
         end
         if (req.ready) begin
            valid_ff <= req.valid;
         end
      end
   end

   // Payload of the request.
   always_ff @(posedge clock) begin
      if (accept) begin
         angle_ff <= angle_in;
         range_ff <= req.range_mm;
         kept_ff  <= kept_in;
         last_ff  <= req.scan_end;
      end
   end

   // Starting vector: the inverse gain on the x axis, residual angle within the quadrant.
   always_comb begin
      out_vec.x = srtc_pkg::CORDIC_START;
      out_vec.y = '0;
      out_vec.z = srtc_pkg::Z_W'({angle_ff[ANGLE_BITS-3:0], {(32-ANGLE_BITS){1'b0}}});
   end

   assign out_side  = {range_ff, angle_ff[ANGLE_BITS-1 -: 2], kept_ff, last_ff};
   assign out_valid = valid_ff;

endmodule

`default_nettype wire

// ===== rtl/srtc_cell.sv =====
`default_nettype none

module srtc_cell #(
   parameter int STEP   = 0,
   parameter int SIDE_W = srtc_pkg::RANGE_BITS_DEFAULT + 4
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   output logic                          in_ready,
   input  wire srtc_pkg::cordic_vec_type in_vec,
   input  wire logic [SIDE_W-1:0]        in_side,
   output logic                          out_valid,
   input  wire logic                     out_ready,
   output srtc_pkg::cordic_vec_type      out_vec,
   output logic [SIDE_W-1:0]             out_side
);

   localparam logic signed [srtc_pkg::Z_W-1:0] ATAN_Z =
      srtc_pkg::Z_W'(srtc_pkg::ATAN_TURN[STEP]);

   logic                     valid_ff;
   srtc_pkg::cordic_vec_type vec_ff, vec_in;
   logic [SIDE_W-1:0]        side_ff;
   logic signed [srtc_pkg::X_W-1:0] dx, dy;

   assign in_ready = !valid_ff || out_ready;

   // One rotation step, steered by the sign of the residual angle.
   always_comb begin
      dx = signed'(in_vec.y) >>> STEP;
      dy = signed'(in_vec.x) >>> STEP;
      if (!in_vec.z[srtc_pkg::Z_W-1]) begin
         vec_in.x = in_vec.x - dx;
         vec_in.y = in_vec.y + dy;
         vec_in.z = in_vec.z - ATAN_Z;
      end else begin
         vec_in.x = in_vec.x + dx;
         vec_in.y = in_vec.y - dy;
         vec_in.z = in_vec.z + ATAN_Z;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         vec_ff  <= vec_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_vec   = vec_ff;
   assign out_side  = side_ff;

endmodule

`default_nettype wire

// ===== rtl/srtc_scale.sv =====
`default_nettype none

module srtc_scale #(
   parameter int RANGE_BITS = srtc_pkg::RANGE_BITS_DEFAULT,
   parameter int SIDE_W     = RANGE_BITS + 4
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   output logic                          in_ready,
   input  wire srtc_pkg::cordic_vec_type in_vec,
   input  wire logic [SIDE_W-1:0]        in_side,
   srtc_rsp_if.source                    rsp
);

   localparam int X_W    = srtc_pkg::X_W;
   localparam int MAG_W  = srtc_pkg::MAG_W;
   localparam int PROD_W = MAG_W + RANGE_BITS + 1;
   localparam int P_W    = PROD_W - srtc_pkg::UNIT_SHIFT;
   localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (srtc_pkg::UNIT_SHIFT - 1);
   localparam logic [P_W-1:0]    LIM  = P_W'({RANGE_BITS{1'b1}});

   // Side vector layout: {range, quadrant, kept, last}.
   logic [RANGE_BITS-1:0]  side_range;
   srtc_pkg::quadrant_type side_quad;
   logic                   side_kept, side_last;

   assign side_range = in_side[SIDE_W-1 -: RANGE_BITS];
   assign side_quad  = srtc_pkg::quadrant_type'(in_side[3:2]);
   assign side_kept  = in_side[1];
   assign side_last  = in_side[0];

   // Stage A: quadrant applied, magnitudes and signs.
   logic                  a_valid_ff, a_ready;
   logic [MAG_W-1:0]      a_mag_x_ff, a_mag_y_ff, a_mag_x_in, a_mag_y_in;
   logic                  a_neg_x_ff, a_neg_y_ff;
   logic [RANGE_BITS-1:0] a_range_ff;
   logic                  a_kept_ff, a_last_ff;
   logic signed [X_W-1:0] cos_v, sin_v, abs_x, abs_y;

   // Stage B: products with the rounding half added.
   logic                  b_valid_ff, b_ready;
   logic [PROD_W-1:0]     b_prod_x_ff, b_prod_y_ff;
   logic                  b_neg_x_ff, b_neg_y_ff, b_kept_ff, b_last_ff;

   // Stage C: output register.
   logic                  c_valid_ff, c_ready;
   logic signed [RANGE_BITS:0] c_x_ff, c_y_ff, c_x_in, c_y_in;
   logic                  c_kept_ff, c_last_ff;
   logic [P_W-1:0]        p_x, p_y;
   logic [RANGE_BITS-1:0] sat_x, sat_y;

   assign c_ready  = !c_valid_ff || rsp.ready;
   assign b_ready  = !b_valid_ff || c_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   // Exact swaps and negations for the quadrant.
   always_comb begin
      case (side_quad)
         srtc_pkg::QUAD_FIRST: begin
            cos_v = in_vec.x;
            sin_v = in_vec.y;
         end
         srtc_pkg::QUAD_SECOND: begin
            cos_v = -in_vec.y;
            sin_v = in_vec.x;
         end
         srtc_pkg::QUAD_THIRD: begin
            cos_v = -in_vec.x;
            sin_v = -in_vec.y;
         end
         default: begin
            cos_v = in_vec.y;
            sin_v = -in_vec.x;
         end
      endcase
      abs_x      = cos_v[X_W-1] ? -cos_v : cos_v;
      abs_y      = sin_v[X_W-1] ? -sin_v : sin_v;
      a_mag_x_in = abs_x[MAG_W-1:0];
      a_mag_y_in = abs_y[MAG_W-1:0];
   end

   // Round half away from zero, saturate, restore the sign, zero a rejected beam.
   always_comb begin
      p_x    = b_prod_x_ff[PROD_W-1:srtc_pkg::UNIT_SHIFT];
      p_y    = b_prod_y_ff[PROD_W-1:srtc_pkg::UNIT_SHIFT];
      sat_x  = (p_x > LIM) ? LIM[RANGE_BITS-1:0] : p_x[RANGE_BITS-1:0];
      sat_y  = (p_y > LIM) ? LIM[RANGE_BITS-1:0] : p_y[RANGE_BITS-1:0];
      c_x_in = b_neg_x_ff ? -signed'({1'b0, sat_x}) : signed'({1'b0, sat_x});
      c_y_in = b_neg_y_ff ? -signed'({1'b0, sat_y}) : signed'({1'b0, sat_y});
      if (!b_kept_ff) begin
         c_x_in = '0;
         c_y_in = '0;
      end
   end

   // Stage valids.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         if (a_ready) begin
            a_valid_ff <= in_valid;
         end
         if (b_ready) begin
            b_valid_ff <= a_valid_ff;
         end
         if (c_ready) begin
            c_valid_ff <= b_valid_ff;
         end
      end
   end

   // Stage payloads.
   always_ff @(posedge clock) begin
      if (in_valid && a_ready) begin
         a_mag_x_ff <= a_mag_x_in;
         a_mag_y_ff <= a_mag_y_in;
         a_neg_x_ff <= cos_v[X_W-1];
         a_neg_y_ff <= sin_v[X_W-1];
         a_range_ff <= side_range;
         a_kept_ff  <= side_kept;
         a_last_ff  <= side_last;
      end
      if (a_valid_ff && b_ready) begin
         b_prod_x_ff <= PROD_W'(a_mag_x_ff) * PROD_W'(a_range_ff) + HALF;
         b_prod_y_ff <= PROD_W'(a_mag_y_ff) * PROD_W'(a_range_ff) + HALF;
         b_neg_x_ff  <= a_neg_x_ff;
         b_neg_y_ff  <= a_neg_y_ff;
         b_kept_ff   <= a_kept_ff;
         b_last_ff   <= a_last_ff;
      end
      if (b_valid_ff && c_ready) begin
         c_x_ff    <= c_x_in;
         c_y_ff    <= c_y_in;
         c_kept_ff <= b_kept_ff;
         c_last_ff <= b_last_ff;
      end
   end

   assign rsp.valid        = c_valid_ff;
   assign rsp.point_x      = c_x_ff;
   assign rsp.point_y      = c_y_ff;
   assign rsp.point_kept   = c_kept_ff;
   assign rsp.last_of_scan = c_last_ff;

endmodule

`default_nettype wire

// ===== rtl/scan_range_to_cartesian_points.sv =====
`default_nettype none

// Turns rangefinder beams into Cartesian points. Each request carries one range
// sample; the block tracks the beam angle (start angle on the first beam of a scan,
// then advanced by the step after every beam, wrapping) and returns one result per
// request: x and y rounded to the nearest millimetre, or zeros with point_kept low
// when the range is not strictly inside the window. One request is taken every cycle
// while results are being taken. The request is registered at its accepting edge
// together with the angle tracker and range gate, then passes through the row of
// rotation cells and then through quadrant fix-up, scaling by the range and rounding.
// Every stage has its own valid bit, so the pipeline keeps accepting requests into
// empty stages while a result waits at the output. Configuration writes are taken at
// once; a new start angle applies from the next scan, a new step from the next beam.
module scan_range_to_cartesian_points #(
   parameter int RANGE_BITS = srtc_pkg::RANGE_BITS_DEFAULT,
   parameter int ANGLE_BITS = srtc_pkg::ANGLE_BITS_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   srtc_csr_if.sink   csr_chan,
   srtc_req_if.sink   req_chan,
   srtc_rsp_if.source rsp_chan
);

   localparam int ITERS  = srtc_pkg::CORDIC_ITERS;
   localparam int SIDE_W = RANGE_BITS + 4;

   // Stage k output: k = 0 is the front stage, k = 1..ITERS are the rotation cells.
   logic                     stage_valid [ITERS+1];
   logic                     stage_ready [ITERS+1];
   srtc_pkg::cordic_vec_type stage_vec   [ITERS+1];
   logic [SIDE_W-1:0]        stage_side  [ITERS+1];

   // Angle tracker, range gate and configuration registers.
   srtc_front #(
      .RANGE_BITS (RANGE_BITS),
      .ANGLE_BITS (ANGLE_BITS),
      .SIDE_W     (SIDE_W)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr_chan),
      .req       (req_chan),
      .out_valid (stage_valid[0]),
      .out_ready (stage_ready[0]),
      .out_vec   (stage_vec[0]),
      .out_side  (stage_side[0])
   );

   // Row of rotation cells, one iteration each.
   for (genvar i = 0; i < ITERS; i++) begin : g_cell
      srtc_cell #(
         .STEP   (i),
         .SIDE_W (SIDE_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[i]),
         .in_ready  (stage_ready[i]),
         .in_vec    (stage_vec[i]),
         .in_side   (stage_side[i]),
         .out_valid (stage_valid[i+1]),
         .out_ready (stage_ready[i+1]),
         .out_vec   (stage_vec[i+1]),
         .out_side  (stage_side[i+1])
      );
   end

   // Quadrant, scaling by the range, rounding and the output register.
   srtc_scale #(
      .RANGE_BITS (RANGE_BITS),
      .SIDE_W     (SIDE_W)
   ) u_scale (
      .clock    (clock),
      .reset    (reset),
      .in_valid (stage_valid[ITERS]),
      .in_ready (stage_ready[ITERS]),
      .in_vec   (stage_vec[ITERS]),
      .in_side  (stage_side[ITERS]),
      .rsp      (rsp_chan)
   );

endmodule

`default_nettype wire

// ===== verif/srtc_point_checker.sv =====
// Watches the configuration, request and result channels of the scan converter.
// It keeps its own copy of the registers and of the beam angle tracker, predicts
// the point for every accepted request and compares each accepted result with the
// oldest prediction.
module srtc_point_checker
   import srtc_pkg::*;
(
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_valid,
   input  wire logic                                 csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0]            csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]             csr_data,
   input  wire logic                                 req_valid,
   input  wire logic                                 req_ready,
   input  wire logic [RANGE_BITS_DEFAULT-1:0]        req_range_mm,
   input  wire logic                                 req_scan_end,
   input  wire logic                                 rsp_valid,
   input  wire logic                                 rsp_ready,
   input  wire logic signed [RANGE_BITS_DEFAULT:0]   rsp_point_x,
   input  wire logic signed [RANGE_BITS_DEFAULT:0]   rsp_point_y,
   input  wire logic                                 rsp_point_kept,
   input  wire logic                                 rsp_last_of_scan,
   output int                                        failures,
   output int                                        pending
);

   localparam int RB = RANGE_BITS_DEFAULT;
   localparam int AB = ANGLE_BITS_DEFAULT;

   typedef struct {
      logic signed [RB:0] x;
      logic signed [RB:0] y;
      logic               kept;
      logic               last;
   } beam_point_type;

   // Shadow copy of the registers and of the angle tracker.
   logic [CSR_DATA_BITS-1:0] range_low_reg;
   logic [CSR_DATA_BITS-1:0] range_high_reg;
   logic [CSR_DATA_BITS-1:0] start_angle_reg;
   logic [CSR_DATA_BITS-1:0] angle_step_reg;
   logic [AB-1:0]            beam_angle;
   logic                     scan_start_pending;

   beam_point_type expected_points [$];
   int             fail_tally = 0;

   initial begin
      failures = 0;
      pending  = 0;
   end

   // Multiplies a Q2.30 unit coordinate by the range, rounds half away from zero
   // and saturates to the output range.
   function automatic logic signed [RB:0] scale_mm(longint unit, logic [RB-1:0] range_mm);
      longint unsigned mag;
      longint unsigned prod;
      longint unsigned lim;
      logic signed [RB:0] v;
      lim  = (64'd1 << RB) - 64'd1;
      mag  = (unit < 0) ? -unit : unit;
      prod = (mag * range_mm + (64'd1 << (UNIT_SHIFT - 1))) >> UNIT_SHIFT;
      if (prod > lim) begin
         prod = lim;
      end
      v = prod[RB:0];
      return (unit < 0) ? -v : v;
   endfunction

   // Predicts the point of one beam and advances the angle tracker.
   function automatic beam_point_type predict_point(logic [RB-1:0] range_mm, logic scan_end);
      beam_point_type pt;
      logic [AB-1:0] angle;
      logic [31:0]  turn32;
      quadrant_type quad;
      longint       x;
      longint       y;
      longint       z;
      longint       dx;
      longint       dy;
      longint       cos_q;
      longint       sin_q;
      int           i;
      angle   = scan_start_pending ? AB'($signed(start_angle_reg)) : beam_angle;
      pt.kept = (range_low_reg < range_mm) && (range_mm < range_high_reg);
      pt.last = scan_end;
      pt.x    = '0;
      pt.y    = '0;
      if (pt.kept) begin
         // Rotate within the quadrant, steering by the sign of the residual angle.
         turn32 = 32'(angle) << (32 - AB);
         quad   = quadrant_type'(turn32[31:30]);
         z      = longint'(turn32[29:0]);
         x      = longint'(CORDIC_START);
         y      = 0;
         for (i = 0; i < CORDIC_ITERS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x -= dx;
               y += dy;
               z -= longint'(ATAN_TURN[i]);
            end else begin
               x += dx;
               y -= dy;
               z += longint'(ATAN_TURN[i]);
            end
         end
         // The quadrant is restored by exact swaps and negations.
         case (quad)
            QUAD_FIRST: begin
               cos_q = x;
               sin_q = y;
            end
            QUAD_SECOND: begin
               cos_q = -y;
               sin_q = x;
            end
            QUAD_THIRD: begin
               cos_q = -x;
               sin_q = -y;
            end
            default: begin
               cos_q = y;
               sin_q = -x;
            end
         endcase
         pt.x = scale_mm(cos_q, range_mm);
         pt.y = scale_mm(sin_q, range_mm);
      end
      beam_angle         = angle + AB'(angle_step_reg);
      scan_start_pending = scan_end;
      return pt;
   endfunction

   task automatic flag_mismatch(string field, int want, int got);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      fail_tally++;
   endtask

   // Results are compared before the request of the same edge is predicted.
   always @(posedge clock) begin
      beam_point_type want;
      if (reset) begin
         range_low_reg      = RANGE_LOW_RESET;
         range_high_reg     = RANGE_HIGH_RESET;
         start_angle_reg    = START_ANGLE_RESET;
         angle_step_reg     = ANGLE_STEP_RESET;
         beam_angle         = '0;
         scan_start_pending = 1'b1;
         expected_points.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_points.size() == 0) begin
               $display("%0t: result with no request outstanding, actual x %0d y %0d",
                        $time, rsp_point_x, rsp_point_y);
               fail_tally++;
            end else begin
               want = expected_points.pop_front();
               if (rsp_point_x !== want.x) begin
                  flag_mismatch("point_x", want.x, rsp_point_x);
               end
               if (rsp_point_y !== want.y) begin
                  flag_mismatch("point_y", want.y, rsp_point_y);
               end
               if (rsp_point_kept !== want.kept) begin
                  flag_mismatch("point_kept", want.kept, rsp_point_kept);
               end
               if (rsp_last_of_scan !== want.last) begin
                  flag_mismatch("last_of_scan", want.last, rsp_last_of_scan);
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_points.insert(expected_points.size(),
                                   predict_point(req_range_mm, req_scan_end));
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_RANGE_LOW:   range_low_reg   = csr_data;
               CSR_RANGE_HIGH:  range_high_reg  = csr_data;
               CSR_START_ANGLE: start_angle_reg = csr_data;
               CSR_ANGLE_STEP:  angle_step_reg  = csr_data;
               default: ;
            endcase
         end
      end
      failures <= fail_tally;
      pending  <= expected_points.size();
   end

endmodule

// ===== verif/tb_scan_range_to_cartesian_points.sv =====
// Drives range requests and register writes into the scan converter, applies
// random back-pressure on the result side and gives the verdict.
module tb_scan_range_to_cartesian_points;
   import srtc_pkg::*;

   localparam int STALL_LIMIT     = 2000;
   localparam int DRAIN_CYCLES    = 40;
   localparam int RANDOM_PHASES   = 8;
   localparam int BEAMS_PER_PHASE = 118;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED_INDEX = 8'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LAST_INDEX   = 8'hFF;
   localparam logic [15:0] FULL_SCALE_MM = 16'hFFFF;

   logic clock;
   logic reset;
   int   failures;
   int   pending;
   int   stall_cycles = 0;
   int   sender_idle_pct = 0;
   int   receiver_idle_pct = 0;
   int   cur_lo = 0;
   int   cur_hi = 65535;

   srtc_csr_if csr_bus ();
   srtc_req_if req_bus ();
   srtc_rsp_if rsp_bus ();

   scan_range_to_cartesian_points uut (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_bus),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   srtc_point_checker point_check (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_bus.valid),
      .csr_ready        (csr_bus.ready),
      .csr_index        (csr_bus.index),
      .csr_data         (csr_bus.data),
      .req_valid        (req_bus.valid),
      .req_ready        (req_bus.ready),
      .req_range_mm     (req_bus.range_mm),
      .req_scan_end     (req_bus.scan_end),
      .rsp_valid        (rsp_bus.valid),
      .rsp_ready        (rsp_bus.ready),
      .rsp_point_x      (rsp_bus.point_x),
      .rsp_point_y      (rsp_bus.point_y),
      .rsp_point_kept   (rsp_bus.point_kept),
      .rsp_last_of_scan (rsp_bus.last_of_scan),
      .failures         (failures),
      .pending          (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: ends the run when nothing has been accepted for too long.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Result side: ready drops for random bursts while idling is enabled.
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && receiver_idle_pct != 0 && $urandom_range(0, 99) < receiver_idle_pct) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
      end
   end

   // Offers one beam request, after an optional idle burst, and waits for it to be taken.
   task automatic send_beam(input logic [15:0] range_mm, input logic scan_end);
      if (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.range_mm <= range_mm;
      req_bus.scan_end <= scan_end;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // Holds off requests until every predicted point has come back.
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
   endtask

   // Writes all four registers, plus writes to indexes the block does not decode.
   task automatic configure_sweep(input logic [15:0] lo, input logic [15:0] hi,
                                  input logic [15:0] start, input logic [15:0] step);
      write_reg(CSR_RANGE_LOW, lo);
      write_reg(CSR_UNUSED_INDEX, 16'($urandom()));
      write_reg(CSR_RANGE_HIGH, hi);
      write_reg(CSR_START_ANGLE, start);
      write_reg(CSR_LAST_INDEX, 16'($urandom()));
      write_reg(CSR_ANGLE_STEP, step);
      csr_bus.valid <= 1'b0;
      cur_lo = lo;
      cur_hi = hi;
   endtask

   // Ranges favour the inside of the window and its edges.
   function automatic logic [15:0] pick_range();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 9 && cur_hi - cur_lo >= 2) begin
         return 16'($urandom_range(cur_lo + 1, cur_hi - 1));
      end
      if (pick < 13) begin
         case ($urandom_range(0, 3))
            0: return 16'(cur_lo);
            1: return 16'(cur_lo + 1);
            2: return 16'(cur_hi - 1);
            default: return 16'(cur_hi);
         endcase
      end
      if (pick < 15) begin
         return $urandom_range(0, 1) ? FULL_SCALE_MM : 16'd0;
      end
      return 16'($urandom());
   endfunction

   // Mostly whole scans of random length, with the odd misplaced scan end.
   task automatic random_scans(input int count);
      int   sent;
      int   len;
      int   k;
      logic end_flag;
      sent = 0;
      while (sent < count) begin
         len = $urandom_range(1, 40);
         for (k = 0; k < len && sent < count; k++) begin
            end_flag = (k == len - 1);
            if ($urandom_range(0, 29) == 0) begin
               end_flag = ~end_flag;
            end
            send_beam(pick_range(), end_flag);
            sent++;
         end
      end
   endtask

   initial begin
      logic [15:0] lo;
      logic [15:0] hi;
      logic [15:0] start;
      logic [15:0] step;
      int          phase;

      reset            <= 1'b1;
      csr_bus.valid    <= 1'b0;
      csr_bus.index    <= '0;
      csr_bus.data     <= '0;
      req_bus.valid    <= 1'b0;
      req_bus.range_mm <= '0;
      req_bus.scan_end <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: zero and full-scale ranges sit on the window limits.
      sender_idle_pct   = 10;
      receiver_idle_pct = 10;
      send_beam(16'd0, 1'b0);
      send_beam(FULL_SCALE_MM, 1'b0);
      send_beam(16'd1, 1'b0);
      send_beam(16'd65534, 1'b1);
      send_beam(16'd30000, 1'b0);
      wait_drained();

      // Narrow window with a quarter-turn step, so the beams visit every quadrant.
      configure_sweep(16'd100, 16'd200, 16'h0000, 16'h4000);
      send_beam(16'd101, 1'b0);
      send_beam(16'd100, 1'b0);
      send_beam(16'd199, 1'b0);
      send_beam(16'd150, 1'b0);
      send_beam(16'd200, 1'b1);
      wait_drained();

      // Inverted window: every beam is rejected.
      configure_sweep(16'd65535, 16'd0, 16'h7FFF, 16'hFFFF);
      send_beam(16'd40000, 1'b0);
      send_beam(16'd1, 1'b0);
      send_beam(16'd65534, 1'b1);
      wait_drained();

      // Window with no integer strictly inside it.
      configure_sweep(16'd500, 16'd501, 16'h7FFF, 16'hFFFF);
      send_beam(16'd500, 1'b0);
      send_beam(16'd501, 1'b1);
      wait_drained();

      // Full window with a zero step, near full-scale ranges to reach saturation.
      configure_sweep(16'd0, 16'd65535, 16'hC000, 16'h0000);
      send_beam(16'd65534, 1'b0);
      send_beam(16'd65534, 1'b0);
      send_beam(16'd1, 1'b0);
      send_beam(16'd12345, 1'b1);
      wait_drained();

      // Registers changed in the middle of a scan.
      configure_sweep(16'd0, 16'd65535, 16'h8000, 16'd1000);
      send_beam(16'd20000, 1'b0);
      send_beam(16'd20000, 1'b0);
      wait_drained();
      configure_sweep(16'd0, 16'd65535, 16'h1234, 16'd7);
      send_beam(16'd20000, 1'b0);
      send_beam(16'd20000, 1'b1);
      send_beam(16'd20000, 1'b0);
      wait_drained();

      // Random part: each phase picks new settings, idle rates and scans.
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case ($urandom_range(0, 5))
            0: begin
               lo = 16'd0;
               hi = FULL_SCALE_MM;
            end
            1: begin
               lo = 16'($urandom());
               hi = lo + 16'd1;
            end
            2: begin
               lo = FULL_SCALE_MM;
               hi = 16'd0;
            end
            default: begin
               lo = 16'($urandom_range(0, 30000));
               hi = 16'($urandom_range(lo, 65535));
            end
         endcase
         case ($urandom_range(0, 4))
            0: start = 16'h8000;
            1: start = 16'h7FFF;
            2: start = 16'h0000;
            3: start = 16'hFFFF;
            default: start = 16'($urandom());
         endcase
         case ($urandom_range(0, 4))
            0: step = 16'd0;
            1: step = 16'hFFFF;
            2: step = 16'h4000;
            3: step = 16'($urandom_range(1, 400));
            default: step = 16'($urandom());
         endcase
         if (phase == RANDOM_PHASES - 1) begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
         end else begin
            sender_idle_pct   = $urandom_range(0, 3) * 8;
            receiver_idle_pct = $urandom_range(0, 3) * 8;
         end
         configure_sweep(lo, hi, start, step);
         if (phase == 2) begin
            // Sender holds off in mid-phase until the pipeline has emptied.
            random_scans(BEAMS_PER_PHASE / 2);
            wait_drained();
            random_scans(BEAMS_PER_PHASE - BEAMS_PER_PHASE / 2);
         end else begin
            random_scans(BEAMS_PER_PHASE);
         end
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending != 0) begin
         $display("%0t: %0d expected results never arrived", $time, pending);
      end
      if (failures == 0 && pending == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
